// ===== design/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_RESET(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_RESET(label, clk, prop)
`endif
`endif

// ===== design/nce_pkg.sv =====
`default_nettype none
package nce_pkg;
   localparam int DataDepth = 16;

   typedef enum logic [3:0] {
      OP_KA, OP_AO, OP_CH, OP_CY, OP_AM, OP_MA, OP_MPLUS, OP_MMINUS,
      OP_TIA, OP_AIA, OP_TIY, OP_AIY, OP_CIA, OP_CIY, OP_CAL, OP_JUMP
   } op_type;

   typedef enum logic [3:0] {
      SUB_RSTO, SUB_SETR, SUB_RSTR, SUB_INPT, SUB_CMPL, SUB_CHNG, SUB_SIFT, SUB_ENDS,
      SUB_ERRS, SUB_SHTS, SUB_LONS, SUB_SUND, SUB_TIMR, SUB_DSPR, SUB_DEMM, SUB_DEMP
   } sub_type;

   localparam logic [2:0] SND_NONE  = 3'd0;
   localparam logic [2:0] SND_END   = 3'd1;
   localparam logic [2:0] SND_ERR   = 3'd2;
   localparam logic [2:0] SND_SHORT = 3'd3;
   localparam logic [2:0] SND_LONG  = 3'd4;
   localparam logic [2:0] SND_NOTE  = 3'd5;
   localparam logic [2:0] SND_TIMER = 3'd6;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request and execute it, apart from the ripple
      logic ripple;  // one decimal-add ripple step
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ripple_start; // captured op needs the decimal-add ripple
      logic ripple_done;  // current ripple step ends the chain
   } status_type;
endpackage
`default_nettype wire

// ===== design/nce_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module nce_ctrl
   import nce_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output cmd_type    cmd,
   input  wire status_type status
);
   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_RIPPLE, ST_OUT} state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.load     = 1'b0;
      cmd.ripple   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.ripple_start) begin
               state_in = ST_RIPPLE;
            end else begin
               state_in     = ST_OUT;
               rsp_valid_in = 1'b1;
            end
         end
         ST_RIPPLE: begin
            cmd.ripple = 1'b1;
            if (status.ripple_done) begin
               state_in     = ST_OUT;
               rsp_valid_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_IMPL(a_valid_in_out, clock, reset, rsp_valid_ff == (state_ff == ST_OUT))
   `ASSERT_IMPL(a_no_overlap, clock, reset, !(req_valid && !req_stall && rsp_valid))
   `ASSERT_IMPL(a_ripple_after_exec, clock, reset,
      (state_ff == ST_RIPPLE) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_RIPPLE))
endmodule
`default_nettype wire

// ===== design/nce_dp.sv =====
`default_nettype none
`include "assert_macros.svh"
module nce_dp
   import nce_pkg::*;
#(
   parameter int DATA_DEPTH = DataDepth
) (
   input  wire         clock,
   input  wire         reset,
   input  wire cmd_type cmd,
   output status_type  status,
   input  wire  [3:0]  req_mode,
   input  wire  [3:0]  req_operand_first,
   input  wire  [3:0]  req_operand_second,
   input  wire         req_key_pressed,
   input  wire  [3:0]  req_key_code,
   output logic [7:0]  rsp_next_address,
   output logic        rsp_exec_flag,
   output logic [3:0]  rsp_acc_value,
   output logic [7:0]  rsp_number_led,
   output logic [6:0]  rsp_binary_led,
   output logic [2:0]  rsp_sound_request,
   output logic [3:0]  rsp_sound_argument
);
   localparam int AW = $clog2(DATA_DEPTH);

   logic [3:0] a_ff, b_ff, y_ff, z_ff, a_in, b_in, y_in, z_in;
   logic [3:0] a2_ff, b2_ff, y2_ff, z2_ff, a2_in, b2_in, y2_in, z2_in;
   logic [DATA_DEPTH-1:0][3:0] mem_ff, mem_in;
   logic [7:0] pc_ff, pc_in;
   logic       flag_ff, flag_in;
   logic [7:0] num_ff, num_in;
   logic [6:0] bin_ff, bin_in;
   logic [2:0] req_ff, req_in;
   logic [3:0] arg_ff, arg_in;
   logic [AW-1:0] ridx_ff, ridx_in;
   logic       start_ff, start_in;
   logic       done;

   logic [3:0] my, ma_sum_nib, rv;
   logic [4:0] sum5, rsum;
   logic [AW-1:0] yi, ym1;
   op_type     op;
   sub_type    sub;

   always_comb begin
      op   = op_type'(req_mode);
      sub  = sub_type'(req_operand_first);
      yi   = y_ff[AW-1:0];
      ym1  = yi - 1'b1;
      my   = mem_ff[yi];
      a_in = a_ff; b_in = b_ff; y_in = y_ff; z_in = z_ff;
      a2_in = a2_ff; b2_in = b2_ff; y2_in = y2_ff; z2_in = z2_ff;
      mem_in = mem_ff; pc_in = pc_ff; flag_in = flag_ff;
      num_in = num_ff; bin_in = bin_ff; req_in = req_ff; arg_in = arg_ff;
      ridx_in = ridx_ff; start_in = 1'b0;
      sum5 = 5'd0; ma_sum_nib = 4'd0;
      // ripple step: add one carry at ridx
      rv   = mem_ff[ridx_ff];
      rsum = {1'b0, rv} + 5'd1;
      done = 1'b1;
      if (cmd.load) begin
         req_in = SND_NONE;
         arg_in = 4'd0;
         flag_in = 1'b1;
         pc_in = pc_ff + ((req_mode[3] == 1'b0) ? 8'd1 : ((op == OP_JUMP) ? 8'd3 : 8'd2));
         case (op)
            OP_KA: begin
               if (req_key_pressed) a_in = req_key_code;
               flag_in = !req_key_pressed;
            end
            OP_AO: num_in = {4'd0, a_ff};
            OP_CH: begin
               a_in = b_ff; b_in = a_ff; y_in = z_ff; z_in = y_ff;
            end
            OP_CY: begin
               a_in = y_ff; y_in = a_ff;
            end
            OP_AM: mem_in[yi] = a_ff;
            OP_MA: a_in = my;
            OP_MPLUS: begin
               sum5 = {1'b0, my} + {1'b0, a_ff};
               a_in = sum5[3:0]; flag_in = sum5[4];
            end
            OP_MMINUS: begin
               a_in = my - a_ff; flag_in = my < a_ff;
            end
            OP_TIA: a_in = req_operand_first;
            OP_AIA: begin
               sum5 = {1'b0, a_ff} + {1'b0, req_operand_first};
               a_in = sum5[3:0]; flag_in = sum5[4];
            end
            OP_TIY: y_in = req_operand_first;
            OP_AIY: begin
               sum5 = {1'b0, y_ff} + {1'b0, req_operand_first};
               y_in = sum5[3:0]; flag_in = sum5[4];
            end
            OP_CIA: flag_in = a_ff != req_operand_first;
            OP_CIY: flag_in = y_ff != req_operand_first;
            OP_CAL: begin
               if (flag_ff) begin
                  unique case (sub)
                     SUB_RSTO: num_in = 8'hff;
                     SUB_SETR: if (y_ff <= 4'd6) bin_in[y_ff[2:0]] = 1'b1;
                     SUB_RSTR: if (y_ff <= 4'd6) bin_in[y_ff[2:0]] = 1'b0;
                     SUB_INPT: ;
                     SUB_CMPL: a_in = ~a_ff;
                     SUB_CHNG: begin
                        a_in = a2_ff; b_in = b2_ff; y_in = y2_ff; z_in = z2_ff;
                        a2_in = a_ff; b2_in = b_ff; y2_in = y_ff; z2_in = z_ff;
                     end
                     SUB_SIFT: begin
                        flag_in = !a_ff[0]; a_in = {1'b0, a_ff[3:1]};
                     end
                     SUB_ENDS: req_in = SND_END;
                     SUB_ERRS: req_in = SND_ERR;
                     SUB_SHTS: req_in = SND_SHORT;
                     SUB_LONS: req_in = SND_LONG;
                     SUB_SUND: begin req_in = SND_NOTE; arg_in = a_ff; end
                     SUB_TIMR: begin req_in = SND_TIMER; arg_in = a_ff; end
                     SUB_DSPR: bin_in = {mem_ff[AW'(15)][2:0], mem_ff[AW'(14)]};
                     SUB_DEMM: begin
                        if (my < a_ff) begin
                           mem_in[ym1] = 4'd1;
                           mem_in[yi]  = 4'd10 + my - a_ff;
                        end else begin
                           mem_in[yi] = my - a_ff;
                        end
                        y_in = y_ff - 4'd1;
                     end
                     SUB_DEMP: begin
                        // first digit here, carries ripple over later cycles
                        sum5 = {1'b0, my} + {1'b0, a_ff};
                        if (sum5 < 5'd10) begin
                           mem_in[yi] = sum5[3:0];
                        end else begin
                           ma_sum_nib = 4'(sum5 - 5'd10);
                           mem_in[yi] = ma_sum_nib;
                           start_in = 1'b1;
                           ridx_in = ym1;
                        end
                        y_in = y_ff - 4'd1;
                     end
                     default: ;
                  endcase
               end
            end
            default: begin
               if (flag_ff) pc_in = {req_operand_first, req_operand_second};
            end
         endcase
      end else if (cmd.ripple) begin
         if (rsum < 5'd10) begin
            mem_in[ridx_ff] = rsum[3:0];
         end else begin
            mem_in[ridx_ff] = 4'(rsum - 5'd10);
            done = 1'b0;
            ridx_in = ridx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; y_ff <= '0; z_ff <= '0;
         a2_ff <= '0; b2_ff <= '0; y2_ff <= '0; z2_ff <= '0;
         mem_ff <= '0; pc_ff <= '0; flag_ff <= 1'b1;
         num_ff <= 8'hff; bin_ff <= '0; req_ff <= SND_NONE; arg_ff <= '0;
         start_ff <= 1'b0;
      end else begin
         a_ff <= a_in; b_ff <= b_in; y_ff <= y_in; z_ff <= z_in;
         a2_ff <= a2_in; b2_ff <= b2_in; y2_ff <= y2_in; z2_ff <= z2_in;
         mem_ff <= mem_in; pc_ff <= pc_in; flag_ff <= flag_in;
         num_ff <= num_in; bin_ff <= bin_in; req_ff <= req_in; arg_ff <= arg_in;
         start_ff <= cmd.load ? start_in : start_ff;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= ridx_in;
   end

   assign status.ripple_start = start_ff;
   assign status.ripple_done  = done;

   assign rsp_next_address   = pc_ff;
   assign rsp_exec_flag      = flag_ff;
   assign rsp_acc_value      = a_ff;
   assign rsp_number_led     = num_ff;
   assign rsp_binary_led     = bin_ff;
   assign rsp_sound_request  = req_ff;
   assign rsp_sound_argument = arg_ff;

   `ASSERT_IMPL(a_cmd_excl, clock, reset, !(cmd.load && cmd.ripple))
   `ASSERT_IMPL(a_arg_zero, clock, reset,
      (req_ff != SND_NOTE && req_ff != SND_TIMER) |-> (arg_ff == 4'd0))
   `ASSERT_IMPL(a_req_range, clock, reset, req_ff <= SND_TIMER)
endmodule
`default_nettype wire

// ===== design/nibble_cpu_instruction_execute.sv =====
// Executes one instruction of a 4-bit trainer computer per transfer.
// Request channel: req_valid/req_stall with opcode, operands and keypad
// state. Response channel: rsp_valid/rsp_stall with the new program
// address, flag, A, both LED latches and a sound request.
// One instruction is in flight at a time: req_stall is high from the
// accepting edge until the response transfer completes.
// An accepted request passes through the controller states EXEC and OUT;
// rsp_valid is registered and rises on entering OUT. Decimal add (CAL DEM+)
// adds RIPPLE between them, one ripple step per carry rippled through the
// data nibbles. A new request is taken only after the response transfer.
// Reset clears both register sets and the data nibbles, program address 0, flag 1,
// number latch blank (255), binary latch 0.
// While the receiver stalls, the response holds and no request is taken.
`default_nettype none
module nibble_cpu_instruction_execute
   import nce_pkg::*;
#(
   parameter int DATA_DEPTH = DataDepth
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [3:0] req_mode,
   input  wire  [3:0] req_operand_first,
   input  wire  [3:0] req_operand_second,
   input  wire        req_key_pressed,
   input  wire  [3:0] req_key_code,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [7:0] rsp_next_address,
   output logic       rsp_exec_flag,
   output logic [3:0] rsp_acc_value,
   output logic [7:0] rsp_number_led,
   output logic [6:0] rsp_binary_led,
   output logic [2:0] rsp_sound_request,
   output logic [3:0] rsp_sound_argument
);
   cmd_type    cmd;
   status_type status;

   nce_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .status
   );

   nce_dp #(.DATA_DEPTH(DATA_DEPTH)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_mode, .req_operand_first, .req_operand_second,
      .req_key_pressed, .req_key_code,
      .rsp_next_address, .rsp_exec_flag, .rsp_acc_value, .rsp_number_led,
      .rsp_binary_led, .rsp_sound_request, .rsp_sound_argument
   );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import nce_pkg::*;

   localparam int NumRandom = 1650;
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [7:0] next_address;
      logic       exec_flag;
      logic [3:0] acc_value;
      logic [7:0] number_led;
      logic [6:0] binary_led;
      logic [2:0] sound_request;
      logic [3:0] sound_argument;
   } cpu_result_type;

   class cpu_scoreboard;
      logic [3:0] regs [4];
      logic [3:0] alt_regs [4];
      logic [3:0] dmem [16];
      logic [7:0] pc;
      logic       flag;
      logic [7:0] num_latch;
      logic [6:0] bin_latch;
      cpu_result_type pending [$];
      int errors;
      int checked;

      function new();
         for (int k = 0; k < 4; k++) begin
            regs[k] = 0;
            alt_regs[k] = 0;
         end
         for (int k = 0; k < 16; k++) dmem[k] = 0;
         pc = 0;
         flag = 1;
         num_latch = 8'hff;
         bin_latch = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void decimal_add();
         logic [3:0] idx;
         logic [4:0] addend;
         logic [4:0] sum;
         idx = regs[2];
         addend = {1'b0, regs[0]};
         for (int n = 0; n < 32; n++) begin
            sum = dmem[idx] + addend;
            if (sum < 5'd10) begin
               dmem[idx] = sum[3:0];
               break;
            end
            dmem[idx] = 4'(sum - 5'd10);
            addend = 5'd1;
            idx = idx - 4'd1;
         end
      endfunction

      function void note_instruction(logic [3:0] mode, logic [3:0] imm, logic [3:0] lo,
                                     logic pressed, logic [3:0] key);
         cpu_result_type r;
         logic [4:0] sum;
         logic [3:0] tmp;
         logic [3:0] m;
         logic [7:0] len;
         logic f;
         r.sound_request = SND_NONE;
         r.sound_argument = 0;
         f = 1;
         len = (mode < 4'd8) ? 8'd1 : ((mode < 4'd15) ? 8'd2 : 8'd3);
         case (op_type'(mode))
            OP_KA: begin
               if (pressed) regs[0] = key;
               f = !pressed;
            end
            OP_AO: num_latch = {4'd0, regs[0]};
            OP_CH: begin
               tmp = regs[0]; regs[0] = regs[1]; regs[1] = tmp;
               tmp = regs[2]; regs[2] = regs[3]; regs[3] = tmp;
            end
            OP_CY: begin
               tmp = regs[0]; regs[0] = regs[2]; regs[2] = tmp;
            end
            OP_AM: dmem[regs[2]] = regs[0];
            OP_MA: regs[0] = dmem[regs[2]];
            OP_MPLUS: begin
               sum = dmem[regs[2]] + regs[0];
               regs[0] = sum[3:0];
               f = sum[4];
            end
            OP_MMINUS: begin
               f = dmem[regs[2]] < regs[0];
               regs[0] = dmem[regs[2]] - regs[0];
            end
            OP_TIA: regs[0] = imm;
            OP_AIA: begin
               sum = regs[0] + imm;
               regs[0] = sum[3:0];
               f = sum[4];
            end
            OP_TIY: regs[2] = imm;
            OP_AIY: begin
               sum = regs[2] + imm;
               regs[2] = sum[3:0];
               f = sum[4];
            end
            OP_CIA: f = regs[0] != imm;
            OP_CIY: f = regs[2] != imm;
            OP_CAL: if (flag) begin
               case (sub_type'(imm))
                  SUB_RSTO: num_latch = 8'hff;
                  SUB_SETR: if (regs[2] <= 4'd6) bin_latch[regs[2]] = 1'b1;
                  SUB_RSTR: if (regs[2] <= 4'd6) bin_latch[regs[2]] = 1'b0;
                  SUB_INPT: ;
                  SUB_CMPL: regs[0] = ~regs[0];
                  SUB_CHNG: for (int k = 0; k < 4; k++) begin
                     tmp = regs[k]; regs[k] = alt_regs[k]; alt_regs[k] = tmp;
                  end
                  SUB_SIFT: begin
                     f = !regs[0][0];
                     regs[0] = regs[0] >> 1;
                  end
                  SUB_ENDS: r.sound_request = SND_END;
                  SUB_ERRS: r.sound_request = SND_ERR;
                  SUB_SHTS: r.sound_request = SND_SHORT;
                  SUB_LONS: r.sound_request = SND_LONG;
                  SUB_SUND: begin
                     r.sound_request = SND_NOTE;
                     r.sound_argument = regs[0];
                  end
                  SUB_TIMR: begin
                     r.sound_request = SND_TIMER;
                     r.sound_argument = regs[0];
                  end
                  SUB_DSPR: bin_latch = {dmem[15][2:0], dmem[14]};
                  SUB_DEMM: begin
                     m = dmem[regs[2]];
                     if (m < regs[0]) begin
                        dmem[regs[2] - 4'd1] = 4'd1;
                        dmem[regs[2]] = 4'd10 + m - regs[0];
                     end else begin
                        dmem[regs[2]] = m - regs[0];
                     end
                     regs[2] = regs[2] - 4'd1;
                  end
                  default: begin
                     decimal_add();
                     regs[2] = regs[2] - 4'd1;
                  end
               endcase
            end
            default: if (flag) begin
               pc = {imm, lo};
               len = 8'd0;
            end
         endcase
         pc = pc + len;
         flag = f;
         r.next_address = pc;
         r.exec_flag = flag;
         r.acc_value = regs[0];
         r.number_led = num_latch;
         r.binary_led = bin_latch;
         pending.insert(pending.size(), r);
      endfunction

      function void check_result(cpu_result_type got);
         cpu_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected response transfer");
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.next_address !== want.next_address) begin
            $error("next_address expected %0d got %0d", want.next_address, got.next_address);
            errors++;
         end
         if (got.exec_flag !== want.exec_flag) begin
            $error("exec_flag expected %0d got %0d", want.exec_flag, got.exec_flag);
            errors++;
         end
         if (got.acc_value !== want.acc_value) begin
            $error("acc_value expected %0d got %0d", want.acc_value, got.acc_value);
            errors++;
         end
         if (got.number_led !== want.number_led) begin
            $error("number_led expected %0d got %0d", want.number_led, got.number_led);
            errors++;
         end
         if (got.binary_led !== want.binary_led) begin
            $error("binary_led expected %0h got %0h", want.binary_led, got.binary_led);
            errors++;
         end
         if (got.sound_request !== want.sound_request) begin
            $error("sound_request expected %0d got %0d", want.sound_request,
                   got.sound_request);
            errors++;
         end
         if (got.sound_argument !== want.sound_argument) begin
            $error("sound_argument expected %0d got %0d", want.sound_argument,
                   got.sound_argument);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [3:0] req_mode;
   logic [3:0] req_operand_first;
   logic [3:0] req_operand_second;
   logic       req_key_pressed;
   logic [3:0] req_key_code;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_next_address;
   logic       rsp_exec_flag;
   logic [3:0] rsp_acc_value;
   logic [7:0] rsp_number_led;
   logic [6:0] rsp_binary_led;
   logic [2:0] rsp_sound_request;
   logic [3:0] rsp_sound_argument;

   cpu_scoreboard board;
   int cycle_count;
   int sent;

   nibble_cpu_instruction_execute u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_operand_first(req_operand_first),
      .req_operand_second(req_operand_second), .req_key_pressed(req_key_pressed),
      .req_key_code(req_key_code),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_next_address(rsp_next_address), .rsp_exec_flag(rsp_exec_flag),
      .rsp_acc_value(rsp_acc_value), .rsp_number_led(rsp_number_led),
      .rsp_binary_led(rsp_binary_led), .rsp_sound_request(rsp_sound_request),
      .rsp_sound_argument(rsp_sound_argument)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Send one instruction: idle a random gap, then hold valid until transfer.
   task automatic send_instr(logic [3:0] mode, logic [3:0] imm, logic [3:0] lo,
                             logic pressed, logic [3:0] key);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_operand_first <= imm;
      req_operand_second <= lo;
      req_key_pressed <= pressed;
      req_key_code <= key;
      do @(posedge clock); while (req_stall);
      board.note_instruction(mode, imm, lo, pressed, key);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random();
      int pick;
      logic [3:0] mode;
      logic [3:0] imm;
      pick = $urandom_range(0, 9);
      mode = 4'($urandom());
      imm = 4'($urandom());
      // bias toward CAL and memory ops, where most behavior lives
      if (pick < 3) mode = OP_CAL;
      else if (pick == 3) mode = OP_TIY;
      else if (pick == 4) begin
         mode = OP_AM;
      end
      if (mode == OP_TIY && $urandom_range(0, 1)) imm = 4'($urandom_range(0, 8));
      send_instr(mode, imm, 4'($urandom()), 1'($urandom()), 4'($urandom()));
   endtask

   // Response side: draw a stall length per result, then accept.
   initial begin
      rsp_stall = 1;
      forever begin
         int wait_cycles;
         @(negedge clock);
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (wait_cycles > 0) begin
            rsp_stall <= 1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
         board.check_result('{rsp_next_address, rsp_exec_flag, rsp_acc_value,
                              rsp_number_led, rsp_binary_led, rsp_sound_request,
                              rsp_sound_argument});
      end
   end

   initial begin
      board = new();
      cycle_count = 0;
      sent = 0;
      reset = 1;
      req_valid = 0;
      req_mode = 0;
      req_operand_first = 0;
      req_operand_second = 0;
      req_key_pressed = 0;
      req_key_code = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, every main op, key up/down, skipped JUMP
      send_instr(OP_KA, 0, 0, 0, 4'hf);
      send_instr(OP_KA, 0, 0, 1, 4'hf);
      send_instr(OP_AO, 0, 0, 0, 0);
      send_instr(OP_TIY, 4'hf, 0, 0, 0);
      send_instr(OP_AM, 0, 0, 0, 0);
      send_instr(OP_AIA, 4'hf, 0, 0, 0);
      send_instr(OP_MPLUS, 0, 0, 0, 0);
      send_instr(OP_MMINUS, 0, 0, 0, 0);
      send_instr(OP_JUMP, 4'hf, 4'hf, 0, 0);
      send_instr(OP_CIA, 4'h0, 0, 0, 0);
      send_instr(OP_CAL, SUB_CMPL, 0, 0, 0);
      send_instr(OP_JUMP, 4'hf, 4'he, 0, 0);
      send_instr(OP_AIY, 4'hf, 0, 0, 0);
      send_instr(OP_CY, 0, 0, 0, 0);
      send_instr(OP_CH, 0, 0, 0, 0);
      send_instr(OP_TIA, 4'h9, 0, 0, 0);
      send_instr(OP_TIY, 4'h3, 0, 0, 0);
      send_instr(OP_AM, 0, 0, 0, 0);
      send_instr(OP_CAL, SUB_DEMP, 0, 0, 0);
      send_instr(OP_TIY, 4'h7, 0, 0, 0);
      send_instr(OP_CAL, SUB_SETR, 0, 0, 0);
      send_instr(OP_TIY, 4'h0, 0, 0, 0);
      send_instr(OP_CAL, SUB_DEMM, 0, 0, 0);
      send_instr(OP_MA, 0, 0, 0, 0);
      send_instr(OP_CIY, 4'hf, 0, 0, 0);

      for (int i = 0; i < NumRandom; i++) send_random();
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d instructions, checked %0d responses across all ops and sub-ops.",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
